/* rtl/abc_pkg.sv */
`default_nettype none
package abc_pkg;

   localparam int MAX_ROUNDS_DEF = 14;
   localparam int KEY_REG_WIDTH  = 64;
   localparam int CSR_IDX_WIDTH  = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MODE = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEY0 = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEY3 = 3'd4;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] r;
      logic [7:0] p;
      r = 8'h00;
      p = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) r = r ^ p;
         p = xtime(p);
      end
      gmul = r;
   endfunction

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
      logic [7:0] a0, a1, a2, a3;
      logic [3:0] m0, m1, m2, m3;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      m0 = inv ? 4'he : 4'h2;
      m1 = inv ? 4'hb : 4'h3;
      m2 = inv ? 4'hd : 4'h1;
      m3 = inv ? 4'h9 : 4'h1;
      mix_col = {gmul(a0, m0) ^ gmul(a1, m1) ^ gmul(a2, m2) ^ gmul(a3, m3),
                 gmul(a0, m3) ^ gmul(a1, m0) ^ gmul(a2, m1) ^ gmul(a3, m2),
                 gmul(a0, m2) ^ gmul(a1, m3) ^ gmul(a2, m0) ^ gmul(a3, m1),
                 gmul(a0, m1) ^ gmul(a1, m2) ^ gmul(a2, m3) ^ gmul(a3, m0)};
   endfunction

   function automatic logic [63:0] inv_mix_half(input logic [63:0] h);
      inv_mix_half = {mix_col(h[63:32], 1'b1), mix_col(h[31:0], 1'b1)};
   endfunction

   // one round without the key addition (no MixColumns when last) on a 128-bit state, byte 0 in the top bits
   function automatic logic [127:0] round_fn(input logic [127:0] s, input logic inv,
                                             input logic last);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [127:0] o;
      for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inv) t[((c + r) % 4) * 4 + r] = INV_SBOX[b[c*4+r]];
            else t[c*4+r] = SBOX[b[((c + r) % 4) * 4 + r]];
         end
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
      if (!last) begin
         for (int c = 0; c < 4; c++) o[127-32*c -: 32] = mix_col(o[127-32*c -: 32], inv);
      end
      round_fn = o;
   endfunction

   typedef struct packed {
      logic       ready;
      logic [3:0] rounds;
   } key_status_type;

endpackage
`default_nettype wire

/* rtl/abc_ram.sv */
`default_nettype none
module abc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 30
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/abc_key_expand.sv */
`default_nettype none
module abc_key_expand #(
   parameter int MAX_ROUNDS = abc_pkg::MAX_ROUNDS_DEF,
   localparam int DEPTH = 2 * (MAX_ROUNDS + 1),
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [1:0]    key_size_mode,
   input  wire logic [255:0]  key,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [63:0]        enc_data,
   output logic [63:0]        dec_data,
   output abc_pkg::key_status_type status
);
   typedef enum logic [1:0] {IDLE, RUN} state_type;

   state_type        state_ff;
   logic [255:0]     win_ff, win_in;
   logic [5:0]       idx_ff;
   logic [7:0]       rcon_ff, rcon_in;
   logic [3:0]       nk_ff;
   logic [3:0]       nr_ff;
   logic [2:0]       phase_ff;
   logic             ready_ff;
   logic [AW-1:0]    addr_ff;
   logic [AW-1:0]    wr_addr_ff;
   logic [63:0]      half_ff;
   logic [31:0]      prev_ff;
   logic             wr_ff;
   logic [63:0]      enc_ff;
   logic [63:0]      dec_ff;
   logic [1:0]       mode_eff;
   logic [31:0]      t_word, new_word;
   logic [5:0]       total;
   logic             half_done;

   always_comb begin
      mode_eff = (key_size_mode == 2'd3) ? 2'd2 : key_size_mode;
      if (MAX_ROUNDS < 14 && mode_eff == 2'd2) mode_eff = 2'd1;
      if (MAX_ROUNDS < 12 && mode_eff == 2'd1) mode_eff = 2'd0;
   end

   assign total = 6'({nr_ff, 2'b00} + 6'd4);

   // word generation: window holds the last nk words, newest at bottom
   always_comb begin
      t_word = prev_ff;
      rcon_in = rcon_ff;
      if (phase_ff == 3'd0) begin
         t_word = abc_pkg::sub_word({prev_ff[23:0], prev_ff[31:24]}) ^ {rcon_ff, 24'h0};
         rcon_in = abc_pkg::xtime(rcon_ff);
      end else if (nk_ff == 4'd8 && phase_ff == 3'd4) begin
         t_word = abc_pkg::sub_word(prev_ff);
      end
      new_word = win_ff[255 -: 32] ^ t_word;
      win_in = (nk_ff == 4'd4) ? {win_ff[223:128], new_word, 128'h0} :
               (nk_ff == 4'd6) ? {win_ff[223:64], new_word, 64'h0} :
                                 {win_ff[223:0], new_word};
   end

   assign half_done = idx_ff[0];

   always_ff @(posedge clock) begin
      wr_ff <= 1'b0;
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b0;
         nr_ff    <= 4'd10;
      end else begin
         case (state_ff)
            IDLE: begin
               if (start) begin
                  state_ff <= RUN;
                  ready_ff <= 1'b0;
                  nk_ff    <= 4'd4 + {1'b0, mode_eff, 1'b0};
                  nr_ff    <= 4'd10 + {1'b0, mode_eff, 1'b0};
                  win_ff   <= (mode_eff == 2'd0) ? {key[255:128], 128'h0} :
                              (mode_eff == 2'd1) ? {key[255:64], 64'h0} : key;
                  prev_ff  <= (mode_eff == 2'd0) ? key[159:128] :
                              (mode_eff == 2'd1) ? key[95:64] : key[31:0];
                  idx_ff   <= 6'd0;
                  rcon_ff  <= 8'h01;
                  phase_ff <= 3'd0;
                  addr_ff  <= '0;
               end
            end
            RUN: begin
               // emit oldest word; once the key words are used up generate new ones
               half_ff <= {half_ff[31:0], win_ff[255 -: 32]};
               if (half_done) begin
                  wr_ff      <= 1'b1;
                  enc_ff     <= {half_ff[31:0], win_ff[255 -: 32]};
                  dec_ff     <= (addr_ff < AW'(2) || addr_ff >= AW'({nr_ff, 1'b0}))
                                ? {half_ff[31:0], win_ff[255 -: 32]}
                                : abc_pkg::inv_mix_half({half_ff[31:0], win_ff[255 -: 32]});
                  wr_addr_ff <= addr_ff;
                  addr_ff    <= addr_ff + AW'(1);
               end
               win_ff   <= win_in;
               prev_ff  <= new_word;
               rcon_ff  <= rcon_in;
               phase_ff <= (phase_ff == 3'(nk_ff - 4'd1)) ? 3'd0 : phase_ff + 3'd1;
               idx_ff   <= idx_ff + 6'd1;
               if (idx_ff == total - 6'd1) begin
                  state_ff <= IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign wr_en         = wr_ff;
   assign wr_addr       = wr_addr_ff;
   assign enc_data      = enc_ff;
   assign dec_data      = dec_ff;
   assign status.ready  = ready_ff && !wr_ff;
   assign status.rounds = nr_ff;
endmodule
`default_nettype wire

/* rtl/abc_round.sv */
`default_nettype none
module abc_round #(
   parameter int MAX_ROUNDS = abc_pkg::MAX_ROUNDS_DEF,
   localparam int AW = $clog2(2 * (MAX_ROUNDS + 1))
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          op,
   input  wire logic [127:0]  block,
   input  wire logic [3:0]    rounds,
   output logic [AW-1:0]      rd_addr,
   output logic               rd_sel,
   input  wire logic [63:0]   rd_data,
   output logic               busy,
   output logic               done,
   output logic [127:0]       result
);
   typedef enum logic [1:0] {IDLE, FETCH, APPLY} state_type;

   state_type      state_ff;
   logic [127:0]   s_ff;
   logic [63:0]    khi_ff;
   logic           op_ff;
   logic [3:0]     r_ff;
   logic           part_ff;
   logic           done_ff;
   logic [3:0]     kr;
   logic [127:0]   rk;
   logic           first, last;

   // key round index for the current step
   assign kr     = op_ff ? (rounds - r_ff) : r_ff;
   assign rd_addr = AW'({kr, part_ff});
   assign rd_sel  = op_ff;
   assign rk      = {khi_ff, rd_data};
   assign first   = (r_ff == 4'd0);
   assign last    = (r_ff == rounds);

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         case (state_ff)
            IDLE: begin
               if (start) begin
                  state_ff <= FETCH;
                  s_ff     <= block;
                  op_ff    <= op;
                  r_ff     <= 4'd0;
                  part_ff  <= 1'b0;
               end
            end
            FETCH: begin
               part_ff  <= 1'b1;
               state_ff <= APPLY;
            end
            APPLY: begin
               if (part_ff) begin
                  khi_ff  <= rd_data;
                  part_ff <= 1'b0;
               end else begin
                  s_ff <= (first ? s_ff : abc_pkg::round_fn(s_ff, op_ff, last)) ^ rk;
                  if (last) begin
                     state_ff <= IDLE;
                     done_ff  <= 1'b1;
                  end else begin
                     r_ff     <= r_ff + 4'd1;
                     state_ff <= FETCH;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign busy   = (state_ff != IDLE);
   assign done   = done_ff;
   assign result = s_ff;
endmodule
`default_nettype wire

/* rtl/aes_block_cipher.sv */
// AES-128/192/256 in ECB mode. After reset or any csr write to the mode or
// key registers the key schedule runs and fills the round key memories,
// encrypt and decrypt, before the next request starts. Each round of a
// request passes through the FETCH state for the address and the APPLY state
// once per 64-bit key half, set by the single read port of the key memory.
// One request is in flight, and the next is taken while a finished result
// waits in the output register; a stalled output adds its stall cycles once a
// second result is done.
`default_nettype none
module aes_block_cipher #(
   parameter int MAX_ROUNDS = abc_pkg::MAX_ROUNDS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_op,
   input  wire logic [63:0]                         req_block_high,
   input  wire logic [63:0]                         req_block_low,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [63:0]                              rsp_result_high,
   output logic [63:0]                              rsp_result_low,
   input  wire logic                                csr_write,
   input  wire logic [abc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [abc_pkg::KEY_REG_WIDTH-1:0]   csr_data
);
   localparam int DEPTH = 2 * (MAX_ROUNDS + 1);
   localparam int AW = $clog2(DEPTH);

   logic [1:0]     mode_ff;
   logic [255:0]   key_ff;
   logic           stale_ff;
   logic           kx_wr;
   logic [AW-1:0]  kx_addr;
   logic [63:0]    kx_enc, kx_dec;
   abc_pkg::key_status_type kx_status;
   logic           kx_busy_ff;
   logic [AW-1:0]  rd_addr;
   logic           rd_sel, rd_sel_ff;
   logic [63:0]    enc_q, dec_q;
   logic           rnd_busy, rnd_done;
   logic [127:0]   rnd_result;
   logic           rsp_valid_ff;
   logic [127:0]   rsp_ff;
   logic           pend_ff;
   logic           kx_start;
   logic           rnd_start;
   logic           req_take;

   assign kx_start = stale_ff && !kx_busy_ff && !rnd_busy && !pend_ff;
   assign req_stall = stale_ff || kx_busy_ff || !kx_status.ready || rnd_busy || rnd_done ||
                      pend_ff;
   assign req_take  = req_valid && !req_stall;
   assign rnd_start = req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 2'd0;
         key_ff     <= '0;
         stale_ff   <= 1'b1;
         kx_busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         if (csr_write && csr_index <= abc_pkg::CSR_KEY3) begin
            stale_ff <= 1'b1;
            if (csr_index == abc_pkg::CSR_MODE) mode_ff <= csr_data[1:0];
            else key_ff[255 - 64*(32'(csr_index) - 1) -: 64] <= csr_data;
         end else if (kx_start) begin
            stale_ff <= 1'b0;
         end
         if (kx_start) kx_busy_ff <= 1'b1;
         else if (kx_status.ready) kx_busy_ff <= 1'b0;
         // result buffered while the output register is still full
         if (pend_ff && (!rsp_valid_ff || !rsp_stall)) begin
            pend_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= rnd_result;
         end else begin
            if (rnd_done) pend_ff <= 1'b1;
            if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         end
      end
      rd_sel_ff <= rd_sel;
   end

   abc_key_expand #(.MAX_ROUNDS(MAX_ROUNDS)) u_kx (
      .clock, .reset, .start(kx_start), .key_size_mode(mode_ff), .key(key_ff),
      .wr_en(kx_wr), .wr_addr(kx_addr), .enc_data(kx_enc), .dec_data(kx_dec),
      .status(kx_status)
   );

   abc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_enc_ram (
      .clock, .wr_en(kx_wr), .wr_addr(kx_addr), .wr_data(kx_enc),
      .rd_addr, .rd_data(enc_q)
   );

   abc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_dec_ram (
      .clock, .wr_en(kx_wr), .wr_addr(kx_addr), .wr_data(kx_dec),
      .rd_addr, .rd_data(dec_q)
   );

   abc_round #(.MAX_ROUNDS(MAX_ROUNDS)) u_round (
      .clock, .reset, .start(rnd_start), .op(req_op),
      .block({req_block_high, req_block_low}), .rounds(kx_status.rounds),
      .rd_addr, .rd_sel, .rd_data(rd_sel_ff ? dec_q : enc_q),
      .busy(rnd_busy), .done(rnd_done), .result(rnd_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_ff[127:64];
   assign rsp_result_low  = rsp_ff[63:0];

   a_no_take_stale: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !stale_ff) else $error("request taken with stale keys");
   a_no_kx_during_round: assert property (@(posedge clock) disable iff (reset)
      kx_wr |-> !rnd_busy) else $error("key write during round");
   a_done_needs_slot: assert property (@(posedge clock) disable iff (reset)
      rnd_done |-> !pend_ff) else $error("result overrun");
endmodule
`default_nettype wire
